// ----- rtl/core/dtt_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dtt_pkg: shared types and helpers for the DIV/TIMA timer
// Counter width, clock-select tap table, stream layout and small update
// functions used by the timer core.
// ----------------------------------------------------------------------------
package dtt_pkg;

    // Machine cycle counter, advanced by ticks and cleared by DIV writes
    localparam int unsigned COUNTER_WIDTH = 16;
    typedef logic [COUNTER_WIDTH-1:0] counter_t;

    // Stream widths (fields packed from bit 0 up, padded to whole bytes)
    localparam int unsigned IN_BITS   = 25;
    localparam int unsigned IN_BYTES  = (IN_BITS + 7) / 8;
    localparam int unsigned OUT_BITS  = 17;
    localparam int unsigned OUT_BYTES = (OUT_BITS + 7) / 8;

    // TAC layout
    localparam int unsigned TAC_ENABLE_BIT = 2;
    typedef logic [2:0] tac_t;

    // Clock select codes
    typedef enum logic [1:0] {
        CLK_SEL_1024 = 2'd0,
        CLK_SEL_16   = 2'd1,
        CLK_SEL_64   = 2'd2,
        CLK_SEL_256  = 2'd3
    } clk_sel_t;

    // Counter bit watched for each clock select
    localparam int unsigned SEL_BIT [4] = '{9, 3, 5, 7};

    // Low counter bits that must be zero for a period boundary
    localparam counter_t PERIOD_MASK [4] = '{
        counter_t'(10'h3FF),
        counter_t'(4'hF),
        counter_t'(6'h3F),
        counter_t'(8'hFF)
    };

    localparam logic [7:0] TIMA_MAX = 8'hFF;

    // Result of one TIMA increment
    typedef struct packed {
        logic [7:0] count;
        logic       ovf;
    } bump_t;

    // Increment TIMA, wrapping to zero and flagging overflow
    function automatic bump_t tima_bump(input logic [7:0] count);
        bump_t r;
        if (count == TIMA_MAX)
        begin
            r.count = 8'd0;
            r.ovf   = 1'b1;
        end
        else
        begin
            r.count = count + 8'd1;
            r.ovf   = 1'b0;
        end
        return r;
    endfunction

    // Selected counter bit gated by the timer enable
    function automatic logic edge_signal(input counter_t cnt, input tac_t mode);
        logic b;
        b = 1'b0;
        case (clk_sel_t'(mode[1:0]))
            CLK_SEL_1024: b = cnt[SEL_BIT[0]];
            CLK_SEL_16:   b = cnt[SEL_BIT[1]];
            CLK_SEL_64:   b = cnt[SEL_BIT[2]];
            CLK_SEL_256:  b = cnt[SEL_BIT[3]];
            default:      b = 1'b0;
        endcase
        return b & mode[TAC_ENABLE_BIT];
    endfunction

    // True when the counter sits on a period boundary of the selected clock
    function automatic logic period_hit(input counter_t cnt, input logic [1:0] sel);
        return (cnt & PERIOD_MASK[sel]) == '0;
    endfunction

endpackage

// ----- rtl/core/div_tima_timer_with_edge_glitch_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// div_tima_timer_with_edge_glitch_top: DIV/TIMA timer, one machine cycle per
// transaction
// Applies TAC, TIMA, TMA and DIV writes, the pending reload and the tick of
// one machine cycle, and returns DIV, TIMA and the timer interrupt.
// ----------------------------------------------------------------------------
// Output: the result of a transaction is registered and appears on the output in
// the cycle after it is accepted.
// Throughput: one transaction per cycle; the combinational state update path
// sets the rate. Input is accepted while the output register is empty or is
// being drained; a result that waits on the sink stalls the input.
// Reset: rst_n clears all timer state and the output valid flag.
module div_tima_timer_with_edge_glitch_top
(
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             s_axis_tvalid,
    output logic                             s_axis_tready,
    // tac_write[0], tac_data[3:1], tima_write[4], tima_data[12:5],
    // tma_write[13], tma_data[21:14], div_write[22], cpu_halted[23], tick[24]
    input  logic [dtt_pkg::IN_BYTES*8-1:0]   s_axis_tdata,
    output logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    // div_value[7:0], tima_value[15:8], timer_irq[16]
    output logic [dtt_pkg::OUT_BYTES*8-1:0]  m_axis_tdata
);

    // Unpacked input fields
    logic              tac_write;
    dtt_pkg::tac_t     tac_data;
    logic              tima_write;
    logic [7:0]        tima_data;
    logic              tma_write;
    logic [7:0]        tma_data;
    logic              div_write;
    logic              cpu_halted;
    logic              tick;

    // Timer state
    dtt_pkg::counter_t cnt_reg, cnt_next;
    logic [7:0]        div_reg, div_next;
    logic [7:0]        tima_reg, tima_next;
    logic [7:0]        tma_reg, tma_next;
    dtt_pkg::tac_t     tac_reg, tac_next;
    logic              ovp_reg, ovp_next;
    logic              edge_reg, edge_next;
    logic              irq_next;

    // Output register
    logic              out_valid_reg;
    logic [7:0]        out_div_reg;
    logic [7:0]        out_tima_reg;
    logic              out_irq_reg;

    logic              in_accept;

    assign tac_write  = s_axis_tdata[0];
    assign tac_data   = s_axis_tdata[3:1];
    assign tima_write = s_axis_tdata[4];
    assign tima_data  = s_axis_tdata[12:5];
    assign tma_write  = s_axis_tdata[13];
    assign tma_data   = s_axis_tdata[21:14];
    assign div_write  = s_axis_tdata[22];
    assign cpu_halted = s_axis_tdata[23];
    assign tick       = s_axis_tdata[24];

    // Accept whenever the output register is free or being drained
    assign s_axis_tready = !out_valid_reg || m_axis_tready;
    assign in_accept     = s_axis_tvalid && s_axis_tready;

    // Apply one machine cycle in the order TAC, TIMA, TMA, reload, DIV, tick
    always_comb
    begin
        logic          now;
        dtt_pkg::bump_t b;
        logic [7:0]    tc;
        logic          ovp;
        logic          le;
        dtt_pkg::tac_t mode;
        dtt_pkg::counter_t cnt;
        logic [7:0]    dv;
        logic [7:0]    rm;
        logic          irq;

        now  = 1'b0;
        b    = '0;
        tc   = tima_reg;
        ovp  = ovp_reg;
        le   = edge_reg;
        mode = tac_reg;
        cnt  = cnt_reg;
        dv   = div_reg;
        rm   = tma_reg;
        irq  = 1'b0;

        // TAC change: falling edge on the gated tap bumps TIMA
        if (tac_write && (tac_data != tac_reg))
        begin
            mode = tac_data;
            now  = dtt_pkg::edge_signal(cnt, mode);
            if (le && !now)
            begin
                b   = dtt_pkg::tima_bump(tc);
                tc  = b.count;
                ovp = ovp | b.ovf;
            end
            le = now;
        end

        // TIMA write cancels a pending reload
        if (tima_write)
        begin
            tc  = tima_data;
            ovp = 1'b0;
        end

        if (tma_write)
        begin
            rm = tma_data;
        end

        // Pending reload from TMA with interrupt
        if (ovp)
        begin
            ovp = 1'b0;
            tc  = rm;
            irq = 1'b1;
        end

        // DIV reset: counter drops to zero, so the gated tap falls if it was high
        if (div_write)
        begin
            cnt = '0;
            dv  = 8'd0;
            if (le)
            begin
                b   = dtt_pkg::tima_bump(tc);
                tc  = b.count;
                ovp = ovp | b.ovf;
            end
            le = 1'b0;
        end

        // Advance the cycle counter by one
        if (tick)
        begin
            cnt = cnt + dtt_pkg::counter_t'(1);
            if (cpu_halted)
            begin
                dv = 8'd0;
            end
            else if (cnt[7:0] == 8'd0)
            begin
                dv = dv + 8'd1;
            end
            if (mode[dtt_pkg::TAC_ENABLE_BIT] && dtt_pkg::period_hit(cnt, mode[1:0]))
            begin
                b   = dtt_pkg::tima_bump(tc);
                tc  = b.count;
                ovp = ovp | b.ovf;
            end
            le = dtt_pkg::edge_signal(cnt, mode);
        end

        cnt_next  = cnt;
        div_next  = dv;
        tima_next = tc;
        tma_next  = rm;
        tac_next  = mode;
        ovp_next  = ovp;
        edge_next = le;
        irq_next  = irq;
    end

    // Update timer state on each accepted transaction
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            div_reg  <= 8'd0;
            tima_reg <= 8'd0;
            tma_reg  <= 8'd0;
            tac_reg  <= '0;
            ovp_reg  <= 1'b0;
            edge_reg <= 1'b0;
        end
        else if (in_accept)
        begin
            cnt_reg  <= cnt_next;
            div_reg  <= div_next;
            tima_reg <= tima_next;
            tma_reg  <= tma_next;
            tac_reg  <= tac_next;
            ovp_reg  <= ovp_next;
            edge_reg <= edge_next;
        end
    end

    // Hold the result until the sink takes it
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (in_accept)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_axis_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    // Result payload
    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            out_div_reg  <= div_next;
            out_tima_reg <= tima_next;
            out_irq_reg  <= irq_next;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {{(dtt_pkg::OUT_BYTES*8-dtt_pkg::OUT_BITS){1'b0}},
                            out_irq_reg, out_tima_reg, out_div_reg};

`ifndef NO_ASSERTIONS
    // A pending reload always leaves TIMA reading zero
    a_pending_zero: assert property (@(posedge clk) disable iff (!rst_n)
        ovp_reg |-> (tima_reg == 8'd0))
        else $error("overflow pending with nonzero TIMA");

    // A pending reload not cancelled by a TIMA write raises the interrupt
    a_reload_irq: assert property (@(posedge clk) disable iff (!rst_n)
        (in_accept && ovp_reg && !tima_write) |=> m_axis_tdata[16])
        else $error("pending reload did not raise timer interrupt");

    // A halted tick forces the divider to zero
    a_halt_div: assert property (@(posedge clk) disable iff (!rst_n)
        (in_accept && tick && cpu_halted) |=> (m_axis_tdata[7:0] == 8'd0))
        else $error("divider not held at zero while halted");
`endif

endmodule

// ----- tb/tb_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for the DIV/TIMA timer
// Streams machine cycles into the timer, tracks DIV, TIMA, TMA, TAC and the
// hidden cycle counter in a local timer model, and compares every returned
// DIV/TIMA/interrupt triple in order. Both ports idle and stall at random.
// ----------------------------------------------------------------------------
module tb_top;

    localparam int IN_W         = dtt_pkg::IN_BYTES * 8;
    localparam int OUT_W        = dtt_pkg::OUT_BYTES * 8;
    localparam int RANDOM_ITEMS = 950;
    localparam int STALL_LIMIT  = 2000;
    localparam int REPORT_MAX   = 10;

    // TAC settings used by the directed sequence
    localparam dtt_pkg::tac_t TAC_ON_16   = {1'b1, dtt_pkg::CLK_SEL_16};
    localparam dtt_pkg::tac_t TAC_ON_1024 = {1'b1, dtt_pkg::CLK_SEL_1024};
    localparam dtt_pkg::tac_t TAC_OFF_16  = {1'b0, dtt_pkg::CLK_SEL_16};
    localparam dtt_pkg::tac_t TAC_ON_256  = {1'b1, dtt_pkg::CLK_SEL_256};

    // One machine cycle, tac_write in bit 0 up to tick in bit 24
    typedef struct packed {
        logic          tick;
        logic          cpu_halted;
        logic          div_write;
        logic [7:0]    tma_data;
        logic          tma_write;
        logic [7:0]    tima_data;
        logic          tima_write;
        dtt_pkg::tac_t tac_data;
        logic          tac_write;
    } machine_cycle_t;

    // Returned view, div_value in bit 0 up to timer_irq in bit 16
    typedef struct packed {
        logic       irq;
        logic [7:0] tima;
        logic [7:0] div;
    } timer_view_t;

    typedef struct packed {
        dtt_pkg::counter_t ctr;
        logic [7:0]        div_reg;
        logic [7:0]        tima_reg;
        logic [7:0]        tma_reg;
        dtt_pkg::tac_t     tac_reg;
        logic              ovf_pend;
        logic              last_tap;
        logic              irq_out;
    } timer_state_t;

    typedef struct {
        machine_cycle_t cyc;
        bit             drain_first;
    } queued_cycle_t;

    logic              clk = 1'b0;
    logic              rst_n = 1'b0;
    logic              s_axis_tvalid = 1'b0;
    logic [IN_W-1:0]   s_axis_tdata = '0;
    logic              m_axis_tready = 1'b0;
    wire               s_axis_tready;
    wire               m_axis_tvalid;
    wire [OUT_W-1:0]   m_axis_tdata;

    queued_cycle_t     pending_q[$];
    timer_view_t       timer_expect_q[$];
    timer_state_t      gen_st = '0;
    timer_state_t      model_st = '0;
    machine_cycle_t    tx_item = '0;
    timer_view_t       got_view;
    timer_view_t       want_view;
    bit                next_drain = 1'b0;
    bit                in_fire = 1'b0;
    bit                out_fire = 1'b0;
    int                tx_gap = 0;
    int                rx_hold = 0;
    int                calm_left = 0;
    int                idle_cycles = 0;
    int                mismatches = 0;
    int                results_checked = 0;
    int                irqs_seen = 0;

    div_tima_timer_with_edge_glitch_top dut
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always #5 clk = ~clk;

    // ------------------------------------------------------------------
    // Timer model
    // ------------------------------------------------------------------

    // Counter bit watched by each clock select
    function automatic int tap_of(input logic [1:0] sel);
        int t;
        case (dtt_pkg::clk_sel_t'(sel))
            dtt_pkg::CLK_SEL_1024: t = 9;
            dtt_pkg::CLK_SEL_16:   t = 3;
            dtt_pkg::CLK_SEL_64:   t = 5;
            default:               t = 7;
        endcase
        return t;
    endfunction

    function automatic logic tap_level(input timer_state_t st);
        return st.ctr[tap_of(st.tac_reg[1:0])] & st.tac_reg[dtt_pkg::TAC_ENABLE_BIT];
    endfunction

    // Count TIMA up; a wrap reads zero and arms the reload
    function automatic timer_state_t advance_tima(input timer_state_t st);
        timer_state_t s;
        s = st;
        if (s.tima_reg == dtt_pkg::TIMA_MAX)
        begin
            s.tima_reg = '0;
            s.ovf_pend = 1'b1;
        end
        else
        begin
            s.tima_reg = s.tima_reg + 1'b1;
        end
        return s;
    endfunction

    // A falling tap after a TAC change or DIV reset bumps TIMA
    function automatic timer_state_t glitch_check(input timer_state_t st);
        timer_state_t s;
        logic         lvl;
        s = st;
        lvl = tap_level(s);
        if (s.last_tap && !lvl)
            s = advance_tima(s);
        s.last_tap = lvl;
        return s;
    endfunction

    // Apply one machine cycle in the order TAC, TIMA, TMA, reload, DIV, tick
    function automatic timer_state_t run_machine_cycle(input timer_state_t st,
                                                       input machine_cycle_t c);
        timer_state_t      s;
        logic              en;
        dtt_pkg::counter_t boundary;
        s = st;
        s.irq_out = 1'b0;
        if (c.tac_write && c.tac_data != s.tac_reg)
        begin
            s.tac_reg = c.tac_data;
            s = glitch_check(s);
        end
        en = s.tac_reg[dtt_pkg::TAC_ENABLE_BIT];
        if (c.tima_write)
        begin
            s.tima_reg = c.tima_data;
            s.ovf_pend = 1'b0;
        end
        if (c.tma_write)
            s.tma_reg = c.tma_data;
        if (s.ovf_pend)
        begin
            s.ovf_pend = 1'b0;
            s.tima_reg = s.tma_reg;
            s.irq_out  = 1'b1;
        end
        if (c.div_write)
        begin
            s.ctr     = '0;
            s.div_reg = '0;
            s = glitch_check(s);
        end
        if (c.tick)
        begin
            boundary = (dtt_pkg::counter_t'(1) << (tap_of(s.tac_reg[1:0]) + 1)) - 1'b1;
            s.ctr = s.ctr + 1'b1;
            if (c.cpu_halted)
                s.div_reg = '0;
            else if (s.ctr[7:0] == '0)
                s.div_reg = s.div_reg + 1'b1;
            if (en && (s.ctr & boundary) == '0)
                s = advance_tima(s);
            s.last_tap = tap_level(s);
        end
        return s;
    endfunction

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------

    function automatic machine_cycle_t cycle_of(input logic tac_w, input dtt_pkg::tac_t tac_d,
                                                input logic tima_w, input logic [7:0] tima_d,
                                                input logic tma_w, input logic [7:0] tma_d,
                                                input logic div_w, input logic halt,
                                                input logic tck);
        machine_cycle_t c;
        c.tac_write  = tac_w;
        c.tac_data   = tac_d;
        c.tima_write = tima_w;
        c.tima_data  = tima_d;
        c.tma_write  = tma_w;
        c.tma_data   = tma_d;
        c.div_write  = div_w;
        c.cpu_halted = halt;
        c.tick       = tck;
        return c;
    endfunction

    // Mostly ticking cycles with sparse writes, steered by the current state
    function automatic machine_cycle_t guided_cycle(input timer_state_t st);
        machine_cycle_t c;
        int             pick;
        c = 25'($urandom);
        c.tick       = ($urandom_range(0, 9) != 0);
        c.cpu_halted = ($urandom_range(0, 19) == 0);
        c.div_write  = ($urandom_range(0, 39) == 0);
        c.tac_write  = ($urandom_range(0, 24) == 0);
        c.tima_write = 1'b0;
        c.tma_write  = ($urandom_range(0, 29) == 0);
        if (c.tac_write)
            c.tac_data = {($urandom_range(0, 3) != 0), 2'($urandom_range(0, 3))};
        if (st.ovf_pend)
        begin
            // hit the cycle right after an overflow with writes
            pick = $urandom_range(0, 2);
            c.tima_write = (pick == 0);
            c.tma_write  = (pick == 1);
        end
        else if ($urandom_range(0, 29) == 0)
        begin
            c.tima_write = 1'b1;
            if ($urandom_range(0, 1) == 0)
                c.tima_data = 8'($urandom_range(240, 255));
        end
        return c;
    endfunction

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        else if (r < 88)
            return $urandom_range(1, 3);
        else if (r < 98)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // Queue a cycle and keep the generator's own copy of the state current
    task automatic queue_cycle(input machine_cycle_t c);
        queued_cycle_t q;
        q.cyc = c;
        q.drain_first = next_drain;
        next_drain = 1'b0;
        pending_q.push_back(q);
        gen_st = run_machine_cycle(gen_st, c);
    endtask

    task automatic note_mismatch(input string what, input int unsigned want,
                                 input int unsigned got);
        mismatches++;
        if (mismatches <= REPORT_MAX)
            $display("ERROR result %0d %s: expected %0h, got %0h",
                     results_checked, what, want, got);
    endtask

    // ------------------------------------------------------------------
    // Driver: present input transactions and toggle the result ready
    // ------------------------------------------------------------------
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            // occasional stretches with no idling on either side
            if (calm_left > 0)
                calm_left--;
            else if ($urandom_range(0, 299) == 0)
                calm_left = $urandom_range(40, 200);

            // advance the input side once the held transaction was taken
            if (!s_axis_tvalid || in_fire)
            begin
                if (tx_gap > 0)
                begin
                    tx_gap--;
                    s_axis_tvalid <= 1'b0;
                end
                else if (pending_q.size() > 0 &&
                         !(pending_q[0].drain_first && timer_expect_q.size() > 0))
                begin
                    tx_item = pending_q[0].cyc;
                    pending_q.pop_front();
                    s_axis_tdata  <= IN_W'(tx_item);
                    s_axis_tvalid <= 1'b1;
                    tx_gap = (calm_left > 0) ? 0 : pick_gap();
                end
                else
                begin
                    s_axis_tvalid <= 1'b0;
                end
            end

            // result ready with random stalls
            if (calm_left > 0)
            begin
                m_axis_tready <= 1'b1;
            end
            else if (rx_hold > 0)
            begin
                rx_hold--;
            end
            else if ($urandom_range(0, 99) < 65)
            begin
                m_axis_tready <= 1'b1;
                rx_hold = $urandom_range(0, 10);
            end
            else
            begin
                m_axis_tready <= 1'b0;
                rx_hold = pick_gap();
            end
        end
    end

    // ------------------------------------------------------------------
    // Monitor: predict accepted cycles, check returned views, watchdog
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            in_fire  = s_axis_tvalid && s_axis_tready;
            out_fire = m_axis_tvalid && m_axis_tready;

            if (in_fire)
            begin
                model_st = run_machine_cycle(model_st, tx_item);
                want_view.div  = model_st.div_reg;
                want_view.tima = model_st.tima_reg;
                want_view.irq  = model_st.irq_out;
                timer_expect_q.push_back(want_view);
                if (model_st.irq_out)
                    irqs_seen++;
            end

            if (out_fire)
            begin
                got_view = m_axis_tdata[$bits(timer_view_t)-1:0];
                if (timer_expect_q.size() == 0)
                begin
                    note_mismatch("arrived with nothing outstanding", 0, 32'(got_view));
                end
                else
                begin
                    want_view = timer_expect_q.pop_front();
                    if (got_view.div != want_view.div)
                        note_mismatch("div_value", 32'(want_view.div), 32'(got_view.div));
                    if (got_view.tima != want_view.tima)
                        note_mismatch("tima_value", 32'(want_view.tima),
                                      32'(got_view.tima));
                    if (got_view.irq != want_view.irq)
                        note_mismatch("timer_irq", 32'(want_view.irq), 32'(got_view.irq));
                    results_checked++;
                end
            end

            // end the run if the ports stop moving
            if (in_fire || out_fire)
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= STALL_LIMIT)
            begin
                $display("Watchdog: no transaction for %0d cycles", STALL_LIMIT);
                $display("div_tima_timer_with_edge_glitch_top: mismatch");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------
    // Stimulus and end of run
    // ------------------------------------------------------------------
    initial
    begin
        machine_cycle_t c;
        int             produced;
        int             run_len;
        int             pick;

        produced  = 0;

        // idle cycle, then enable the CLK_SEL_16 clock with TIMA at its top
        queue_cycle(cycle_of(0, '0, 0, 8'h00, 0, 8'h00, 0, 0, 0));
        queue_cycle(cycle_of(1, TAC_ON_16, 1, 8'hFF, 1, 8'h5A, 0, 0, 1));
        // rewrite TAC with the same value: no edge check
        queue_cycle(cycle_of(1, TAC_ON_16, 0, 8'h00, 0, 8'h00, 0, 0, 1));
        // tick until the CLK_SEL_16 tap (counter bit 3) is high
        while (!gen_st.ctr[3])
            queue_cycle(cycle_of(0, '0, 0, 8'h00, 0, 8'h00, 0, 0, 1));
        // DIV reset drops the tap: glitch overflow, then reload with interrupt
        queue_cycle(cycle_of(0, '0, 0, 8'h00, 0, 8'h00, 1, 0, 0));
        queue_cycle(cycle_of(0, '0, 0, 8'h00, 0, 8'h00, 0, 0, 1));
        while (!gen_st.ctr[3])
            queue_cycle(cycle_of(0, '0, 0, 8'h00, 0, 8'h00, 0, 0, 1));
        // clock select change glitch overflows TIMA and reloads it at once, then TIMA and TMA writes
        queue_cycle(cycle_of(0, '0, 1, 8'hFF, 0, 8'h00, 0, 0, 0));
        queue_cycle(cycle_of(1, TAC_ON_1024, 0, 8'h00, 0, 8'h00, 0, 0, 0));
        queue_cycle(cycle_of(0, '0, 1, 8'h12, 1, 8'h77, 0, 0, 0));
        // rising tap, then disabling the timer drops it and reloads at once, then a TMA write
        queue_cycle(cycle_of(1, TAC_ON_16, 1, 8'hFF, 0, 8'h00, 0, 0, 0));
        queue_cycle(cycle_of(1, TAC_OFF_16, 0, 8'h00, 0, 8'h00, 0, 0, 0));
        queue_cycle(cycle_of(0, '0, 0, 8'h00, 1, 8'hFF, 0, 0, 1));
        // every field at its top, halted while ticking
        queue_cycle(cycle_of(1, 3'h7, 1, 8'hFF, 1, 8'hFF, 1, 1, 1));
        queue_cycle(cycle_of(1, TAC_ON_256, 0, 8'h00, 0, 8'h00, 0, 0, 1));

        // random traffic, starting once the directed part has drained
        next_drain = 1'b1;
        while (produced < RANDOM_ITEMS)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 65)
            begin
                run_len = $urandom_range(8, 40);
                repeat (run_len)
                begin
                    queue_cycle(guided_cycle(gen_st));
                    produced++;
                end
            end
            else if (pick < 88)
            begin
                // chase an overflow on a fast clock from just below the top
                c = guided_cycle(gen_st);
                c.tac_write  = 1'b1;
                c.tac_data   = {1'b1, 2'($urandom_range(1, 2))};
                c.tima_write = 1'b1;
                c.tima_data  = 8'($urandom_range(248, 255));
                queue_cycle(c);
                produced++;
                run_len = $urandom_range(20, 80);
                repeat (run_len)
                begin
                    queue_cycle(guided_cycle(gen_st));
                    produced++;
                end
            end
            else
            begin
                run_len = $urandom_range(3, 10);
                repeat (run_len)
                begin
                    queue_cycle(25'($urandom));
                    produced++;
                end
            end
        end

        // hold reset, then release it on a falling edge
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // wait for the last result, then let the output settle
        while (pending_q.size() > 0 || s_axis_tvalid || timer_expect_q.size() > 0)
            @(posedge clk);
        repeat (4) @(posedge clk);

        $display("Checked %0d timer cycles with %0d reload interrupts.",
                 results_checked, irqs_seen);
        $display("Covered TAC and DIV glitches, writes on pending reloads and halted ticks.");
        if (mismatches == 0)
            $display("div_tima_timer_with_edge_glitch_top: match");
        else
            $display("div_tima_timer_with_edge_glitch_top: mismatch");
        $finish;
    end

endmodule
